// ===== rtl/core/asre_pkg.sv =====
// ----------------------------------------------------------------------------
// Spike-rejecting distance filter package
// Shared word types, register indexes and reset values for the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asre_pkg;

	localparam int CFG_DATA_W = 15;

	localparam logic [12:0] STANDOFF_RST = 13'd300;
	localparam logic [8:0]  ALPHA_RST    = 9'd205;
	localparam logic [14:0] SPIKE_RST    = 15'd150;
	localparam logic [7:0]  MAX_OUT_RST  = 8'd5;

	localparam logic [8:0]  ALPHA_MIN    = 9'd3;
	localparam logic [8:0]  ALPHA_MAX    = 9'd256;
	localparam logic [7:0]  COUNT_MAX    = 8'd255;

	typedef enum logic [1:0] {
		CFG_STANDOFF = 2'd0,
		CFG_ALPHA    = 2'd1,
		CFG_SPIKE    = 2'd2,
		CFG_MAX_OUT  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic        mode;
		logic        active_value;
		logic        frame_valid;
		logic [14:0] surface_mm;
	} in_word_t;

	typedef struct packed {
		logic               valid_res;
		logic signed [15:0] x_error;
		logic [14:0]        initial_distance;
	} out_word_t;

endpackage

// ===== rtl/core/asymmetric_spike_reject_ema_unit.sv =====
// ----------------------------------------------------------------------------
// Asymmetric spike-rejecting EMA unit
// Filters the standoff error of each frame: a first value is taken as is,
// large drops are taken at once, large rises wait for repeated confirmation,
// and small changes pass through a Q8 moving average.
// Pipeline: an accepted word is held in the input register, then moves into
// the result register once that register is free of a stalled result.
// Throughput: one word per cycle unless stalled; tracker update is one multiply-add.
// Reset: arst_n clears the tracker and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asymmetric_spike_reject_ema_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  asre_pkg::in_word_t                   item_data,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output asre_pkg::out_word_t                  res_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [asre_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [12:0] standoff_q;
	logic [8:0]  alpha_q;
	logic [14:0] spike_q;
	logic [7:0]  max_out_q;

	logic               active_q, started_q;
	logic signed [16:0] held_q;
	logic [7:0]         count_q;
	logic [14:0]        first_q;

	logic               active_nxt, started_nxt;
	logic signed [16:0] held_nxt;
	logic [7:0]         count_nxt;
	logic [14:0]        first_nxt;

	logic               valid_s1;
	asre_pkg::in_word_t item_s1;
	logic                res_valid_q;
	asre_pkg::out_word_t res_q;
	asre_pkg::out_word_t res_nxt;

	logic load_res, res_free, s1_adv;

	logic signed [16:0] cand;
	logic signed [17:0] delta, spike;
	logic [14:0]        cand_abs;
	logic [8:0]         alpha_c;
	logic signed [27:0] prod, ema_sum;
	logic signed [16:0] ema_val;
	logic [7:0]         count_inc;
	logic               drop, rise;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standoff_q <= asre_pkg::STANDOFF_RST;
			alpha_q    <= asre_pkg::ALPHA_RST;
			spike_q    <= asre_pkg::SPIKE_RST;
			max_out_q  <= asre_pkg::MAX_OUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (asre_pkg::cfg_index_t'(cfg_index))
				asre_pkg::CFG_STANDOFF: standoff_q <= cfg_data[12:0];
				asre_pkg::CFG_ALPHA:    alpha_q    <= cfg_data[8:0];
				asre_pkg::CFG_SPIKE:    spike_q    <= cfg_data[14:0];
				asre_pkg::CFG_MAX_OUT:  max_out_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Datapath for the word held in the input register.
	assign cand     = $signed({2'b00, item_s1.surface_mm}) - $signed({4'b0000, standoff_q});
	assign cand_abs = cand[16] ? 15'(-cand) : cand[14:0];
	assign delta    = 18'(cand) - 18'(held_q);
	assign spike    = $signed({3'b000, spike_q});
	assign drop     = delta < -spike;
	assign rise     = delta > spike;

	always_comb begin
		if (alpha_q < asre_pkg::ALPHA_MIN) begin
			alpha_c = asre_pkg::ALPHA_MIN;
		end else if (alpha_q > asre_pkg::ALPHA_MAX) begin
			alpha_c = asre_pkg::ALPHA_MAX;
		end else begin
			alpha_c = alpha_q;
		end
	end

	// The average is held + floor((alpha * delta + 128) / 256).
	assign prod      = $signed({1'b0, alpha_c}) * delta;
	assign ema_sum   = prod + 28'sd128;
	assign ema_val   = held_q + ema_sum[24:8];
	assign count_inc = (count_q < asre_pkg::COUNT_MAX) ? count_q + 8'd1 : count_q;

	always_comb begin
		active_nxt  = active_q;
		started_nxt = started_q;
		held_nxt    = held_q;
		count_nxt   = count_q;
		first_nxt   = first_q;
		load_res    = 1'b0;
		res_nxt     = '0;
		if (item_s1.mode) begin
			if (item_s1.active_value != active_q) begin
				started_nxt = 1'b0;
				count_nxt   = '0;
				first_nxt   = '0;
			end
			active_nxt = item_s1.active_value;
		end else if (active_q) begin
			load_res = 1'b1;
			if (item_s1.frame_valid) begin
				if (!started_q) begin
					held_nxt          = cand;
					started_nxt       = 1'b1;
					count_nxt         = '0;
					first_nxt         = cand_abs;
					res_nxt.valid_res = 1'b1;
				end else if (drop) begin
					held_nxt          = cand;
					count_nxt         = '0;
					res_nxt.valid_res = 1'b1;
				end else if (rise) begin
					if (count_inc >= max_out_q) begin
						held_nxt          = cand;
						count_nxt         = '0;
						res_nxt.valid_res = 1'b1;
					end else begin
						count_nxt = count_inc;
					end
				end else begin
					held_nxt          = ema_val;
					count_nxt         = '0;
					res_nxt.valid_res = 1'b1;
				end
			end
			if (res_nxt.valid_res) begin
				res_nxt.x_error          = held_nxt[15:0];
				res_nxt.initial_distance = first_nxt;
			end
		end
	end

	assign res_free   = !res_valid_q || !res_stall;
	assign s1_adv     = valid_s1 && (!load_res || res_free);
	assign item_stall = valid_s1 && !s1_adv;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			active_q    <= 1'b0;
			started_q   <= 1'b0;
			held_q      <= '0;
			count_q     <= '0;
			first_q     <= '0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (s1_adv) begin
				active_q  <= active_nxt;
				started_q <= started_nxt;
				held_q    <= held_nxt;
				count_q   <= count_nxt;
				first_q   <= first_nxt;
			end
			if (s1_adv && load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_data;
		end
		if (s1_adv && load_res) begin
			res_q <= res_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_started_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> active_q)
		else $error("tracker running while inactive");

	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (held_q >= -17'sd8191) && (held_q <= 17'sd32767))
		else $error("held distance out of range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.valid_res |-> res_q.x_error == 16'sd0 &&
		res_q.initial_distance == 15'd0)
		else $error("invalid result carries data");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule
